/* rtl/core/mlfr_pkg.sv */
// ---------------------------------------------------------------------------
// Lagged Fibonacci / multiply-with-carry generator package
// Shared types and constants for the request front end, the operation queue
// and the generator back end.
// ---------------------------------------------------------------------------
`default_nettype none

package mlfr_pkg;

   localparam int WORD_W      = 32;
   localparam int INDEX_W     = 5;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 32;
   localparam int HALF_W      = 16;

   localparam int INDEX_LSB = 0;
   localparam int VALUE_LSB = INDEX_LSB + INDEX_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WORD_W-1:0] MWC_MULT    = 32'd30903;
   localparam logic [WORD_W-1:0] CARRY_RESET = 32'd15;
   localparam logic [WORD_W-1:0] ODD_BIT     = 32'h0000_0001;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_DRAW = 1'b1
   } kind_type;

   typedef struct packed {
      logic                draw;
      logic                write_ok;
      logic [INDEX_W-1:0]  index;
      logic [WORD_W-1:0]   value;
   } op_type;

endpackage

`default_nettype wire

/* rtl/core/mult_lagged_fib_mwc_rng.sv */
// ---------------------------------------------------------------------------
// Multiplicative lagged Fibonacci plus multiply-with-carry generator
// Top level: request front end, operation queue and generator back end.
// ---------------------------------------------------------------------------
// The block takes one request per clock while the queue has room and the
// result side does not stall draws, and returns one random word per draw
// through the operation queue and the result register. Load requests write
// one ring word (forced odd) if its index lies in the ring and restart the lag
// pointers and the carry register; they produce no result. Every ring word
// must be loaded before the first draw. The rate of one word per cycle is set
// by the single 32-bit multiply of the two operand registers, which are refetched
// from the ring memory every cycle with forwarding of the word just written.
`default_nettype none

module mult_lagged_fib_mwc_rng #(
   parameter int LONG_LAG  = 17,
   parameter int SHORT_LAG = 5
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0: word_index (5 bits), word_value (32 bits), zero pad.
   input  wire logic [mlfr_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // Fields from bit 0: kind (1 bit).
   input  wire logic                              req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // Fields from bit 0: random_word (32 bits).
   output logic [mlfr_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);
   import mlfr_pkg::*;

   logic   push_valid, push_ready, pop_valid, pop_ready;
   op_type push_op, pop_op;

   mlfr_front #(
      .LONG_LAG(LONG_LAG)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready)
   );

   mlfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op),
      .pop_ready  (pop_ready)
   );

   mlfr_back #(
      .LONG_LAG  (LONG_LAG),
      .SHORT_LAG (SHORT_LAG)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (pop_valid),
      .op         (pop_op),
      .op_pop     (pop_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/core/mlfr_front.sv */
// ---------------------------------------------------------------------------
// Request front end
// Accepts requests, decodes the kind and checks the ring index of a load,
// forces seed words odd and hands the decoded operation to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfr_front #(
   parameter int LONG_LAG = 17
) (
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [mlfr_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                            req_tuser,
   output logic                                 push_valid,
   output mlfr_pkg::op_type                     push_op,
   input  wire logic                            push_ready
);
   import mlfr_pkg::*;

   logic [INDEX_W-1:0] index;
   logic [WORD_W-1:0]  value;

   assign index = req_tdata[VALUE_LSB-1:INDEX_LSB];
   assign value = req_tdata[VALUE_LSB+WORD_W-1:VALUE_LSB];

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   always_comb begin
      push_op.draw     = (kind_type'(req_tuser) == KIND_DRAW);
      push_op.write_ok = (32'(index) < 32'(LONG_LAG));
      push_op.index    = index;
      push_op.value    = value | ODD_BIT;
   end

endmodule

`default_nettype wire

/* rtl/core/mlfr_queue.sv */
// ---------------------------------------------------------------------------
// Operation queue
// A short first-in first-out buffer of decoded operations between the
// front end and the generator back end.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfr_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire mlfr_pkg::op_type push_op,
   output logic                  push_ready,
   output logic                  pop_valid,
   output mlfr_pkg::op_type      pop_op,
   input  wire logic             pop_ready
);
   import mlfr_pkg::*;

   op_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push, do_pop;

   function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
      return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/mlfr_back.sv */
// ---------------------------------------------------------------------------
// Generator back end
// Holds the lag ring, the two lag pointers and the multiply-with-carry
// register, executes load and draw operations and drives the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mlfr_back #(
   parameter int LONG_LAG  = 17,
   parameter int SHORT_LAG = 5
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             op_valid,
   input  wire mlfr_pkg::op_type                 op,
   output logic                                  op_pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [mlfr_pkg::RSP_TDATA_W-1:0]      rsp_tdata
);
   import mlfr_pkg::*;

   localparam int PTR_W = $clog2(LONG_LAG);
   localparam logic [PTR_W-1:0] LONG_START  = PTR_W'(LONG_LAG - 1);
   localparam logic [PTR_W-1:0] SHORT_START = PTR_W'((SHORT_LAG - 1) % LONG_LAG);

   logic [WORD_W-1:0] ring_mem [LONG_LAG];

   logic [PTR_W-1:0]  long_ptr_ff, long_ptr_in;
   logic [PTR_W-1:0]  short_ptr_ff, short_ptr_in;
   logic [WORD_W-1:0] carry_ff, carry_in;
   logic [WORD_W-1:0] oper_long_ff, oper_short_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_data_ff;

   logic              go_draw, go_load;
   logic [WORD_W-1:0] product, mwc_next, carry_low, carry_high, index_ext;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic [WORD_W-1:0] wr_data;

   function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
      return (p == '0) ? LONG_START : p - 1'b1;
   endfunction

   assign go_draw = op_valid && op.draw && (!rsp_valid_ff || rsp_tready);
   assign go_load = op_valid && !op.draw;
   assign op_pop  = go_draw || go_load;

   assign product    = oper_long_ff * oper_short_ff;
   assign carry_low  = {{(WORD_W-HALF_W){1'b0}}, carry_ff[HALF_W-1:0]};
   assign carry_high = {{(WORD_W-HALF_W){1'b0}}, carry_ff[WORD_W-1:HALF_W]};
   assign mwc_next   = carry_low * MWC_MULT + carry_high;
   assign index_ext  = 32'(op.index);

   always_comb begin
      wr_en   = go_draw || (go_load && op.write_ok);
      wr_addr = go_draw ? long_ptr_ff : index_ext[PTR_W-1:0];
      wr_data = go_draw ? product : op.value;

      long_ptr_in  = long_ptr_ff;
      short_ptr_in = short_ptr_ff;
      carry_in     = carry_ff;
      if (go_load) begin
         long_ptr_in  = LONG_START;
         short_ptr_in = SHORT_START;
         carry_in     = CARRY_RESET;
      end else if (go_draw) begin
         long_ptr_in  = step_down(long_ptr_ff);
         short_ptr_in = step_down(short_ptr_ff);
         carry_in     = mwc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_ptr_ff  <= LONG_START;
         short_ptr_ff <= SHORT_START;
         carry_ff     <= CARRY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         long_ptr_ff  <= long_ptr_in;
         short_ptr_ff <= short_ptr_in;
         carry_ff     <= carry_in;
         if (go_draw) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go_draw) begin
         rsp_data_ff <= product + mwc_next;
      end
   end

   // The operand registers always track the ring words under the next pointers,
   // taking the word being written in the same cycle when the addresses match.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
      oper_long_ff  <= (wr_en && wr_addr == long_ptr_in)  ? wr_data : ring_mem[long_ptr_in];
      oper_short_ff <= (wr_en && wr_addr == short_ptr_in) ? wr_data : ring_mem[short_ptr_in];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* dv/mult_lagged_fib_mwc_rng_tb.sv */
// ---------------------------------------------------------------------------
// Testbench for the lagged Fibonacci plus multiply-with-carry generator
// Loads the lag ring, then mixes full and partial reloads, out-of-range loads
// and runs of draws under random stalls on both sides. A scoreboard predicts
// every random word and checks each result request in order.
// ---------------------------------------------------------------------------
module mult_lagged_fib_mwc_rng_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mlfr_pkg::*;

   localparam int LONG_LAG     = 17;
   localparam int SHORT_LAG    = 5;
   localparam int MAX_WAIT     = 19;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_TARGET  = 1850;

   class rng_scoreboard;
      logic [WORD_W-1:0] lag_ring [LONG_LAG];
      int unsigned       long_ptr;
      int unsigned       short_ptr;
      logic [WORD_W-1:0] carry;
      logic [WORD_W-1:0] expected_words [$];
      int unsigned       failures;

      function new();
         foreach (lag_ring[i]) lag_ring[i] = '0;
         failures = 0;
         restart_sequence();
      endfunction

      function void restart_sequence();
         long_ptr  = LONG_LAG - 1;
         short_ptr = (SHORT_LAG - 1) % LONG_LAG;
         carry     = CARRY_RESET;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function void note_request(kind_type kind, logic [INDEX_W-1:0] idx,
                                 logic [WORD_W-1:0] val);
         logic [WORD_W-1:0] product;
         if (kind == KIND_LOAD) begin
            if (idx < LONG_LAG) lag_ring[idx] = val | ODD_BIT;
            restart_sequence();
         end else begin
            product = lag_ring[long_ptr] * lag_ring[short_ptr];
            lag_ring[long_ptr] = product;
            long_ptr  = (long_ptr == 0) ? LONG_LAG - 1 : long_ptr - 1;
            short_ptr = (short_ptr == 0) ? LONG_LAG - 1 : short_ptr - 1;
            carry = carry[HALF_W-1:0] * MWC_MULT + (carry >> HALF_W);
            expected_words.push_back(product + carry);
         end
      endfunction

      function void check_word(logic [WORD_W-1:0] actual);
         logic [WORD_W-1:0] expected;
         if (expected_words.size() == 0) begin
            failures++;
            if (failures <= 10) $display("unexpected random word %h", actual);
         end else begin
            expected = expected_words.pop_front();
            if (expected !== actual) begin
               failures++;
               if (failures <= 10)
                  $display("random word mismatch: expected %h, actual %h", expected, actual);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   rng_scoreboard board;
   bit            burst_req;
   bit            burst_rsp;
   int unsigned   item_count;
   int unsigned   idle_cycles;

   mult_lagged_fib_mwc_rng #(
      .LONG_LAG  (LONG_LAG),
      .SHORT_LAG (SHORT_LAG)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function int unsigned pick_gap(bit burst);
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   function logic [WORD_W-1:0] seed_word();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function logic [INDEX_W-1:0] load_index();
      if ($urandom_range(0, 6) == 0) return INDEX_W'($urandom_range(LONG_LAG, 31));
      return INDEX_W'($urandom_range(0, LONG_LAG - 1));
   endfunction

   task automatic send_request(kind_type kind, logic [INDEX_W-1:0] idx,
                               logic [WORD_W-1:0] val);
      int unsigned            gap;
      logic [REQ_TDATA_W-1:0] packed_word;
      gap = pick_gap(burst_req);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      packed_word = '0;
      packed_word[INDEX_LSB +: INDEX_W] = idx;
      packed_word[VALUE_LSB +: WORD_W]  = val;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= packed_word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(kind, idx, val);
      item_count++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: a fresh stall is drawn for every result request.
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_gap(burst_rsp);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_word(rsp_tdata);
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int unsigned slot [LONG_LAG];
      int unsigned j;
      int unsigned tmp;
      int unsigned count;
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      burst_req  = 1'b0;
      burst_rsp  = 1'b0;
      item_count = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every ring word is loaded before the first draw, with both extremes.
      for (int i = 0; i < LONG_LAG; i++)
         send_request(KIND_LOAD, INDEX_W'(i), (i == 0) ? 32'h0000_0000 :
                      (i == LONG_LAG - 1) ? 32'hFFFF_FFFF : $urandom);
      send_request(KIND_LOAD, INDEX_W'(LONG_LAG), $urandom);
      send_request(KIND_LOAD, 5'd31, 32'hFFFF_FFFF);
      repeat (5) send_request(KIND_DRAW, INDEX_W'($urandom), $urandom);
      drain_results();

      while (item_count < ITEM_TARGET) begin
         burst_req = ($urandom_range(0, 3) == 0);
         burst_rsp = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9)) inside
            [0:2]: begin
               for (int i = 0; i < LONG_LAG; i++) slot[i] = i;
               for (int i = LONG_LAG - 1; i > 0; i--) begin
                  j = $urandom_range(0, i);
                  tmp = slot[i];
                  slot[i] = slot[j];
                  slot[j] = tmp;
               end
               for (int i = 0; i < LONG_LAG; i++)
                  send_request(KIND_LOAD, INDEX_W'(slot[i]), seed_word());
            end
            [3:6]: begin
               repeat ($urandom_range(1, 3))
                  send_request(KIND_LOAD, load_index(), seed_word());
            end
            7: begin
            end
            default: begin
               repeat ($urandom_range(1, 30)) begin
                  if ($urandom_range(0, 9) < 3)
                     send_request(KIND_LOAD, INDEX_W'($urandom), seed_word());
                  else
                     send_request(KIND_DRAW, INDEX_W'($urandom), $urandom);
               end
            end
         endcase
         count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 40);
         repeat (count) send_request(KIND_DRAW, INDEX_W'($urandom), $urandom);
         if ($urandom_range(0, 9) == 0) drain_results();
      end

      drain_results();
      if (board.failures == 0 && board.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/core/mlfr_pkg.sv
rtl/core/mlfr_front.sv
rtl/core/mlfr_queue.sv
rtl/core/mlfr_back.sv
rtl/core/mult_lagged_fib_mwc_rng.sv
dv/mult_lagged_fib_mwc_rng_tb.sv
